FILE: sv/utf8v_pkg.sv
package utf8v_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 21;
  localparam int unsigned LenW   = 20;
  localparam int unsigned PendW  = 2;
  localparam int unsigned SeqW   = 3;

  localparam logic [LenW-1:0] MaxLengthReset = LenW'(255);

  localparam logic [0:0] CfgMaxLength      = 1'b0;
  localparam logic [0:0] CfgAllowMultiline = 1'b1;

  localparam logic [ByteW-1:0] Lead2Min = 8'hc2;
  localparam logic [ByteW-1:0] Lead2Max = 8'hdf;
  localparam logic [ByteW-1:0] Lead3Min = 8'he0;
  localparam logic [ByteW-1:0] Lead3Max = 8'hef;
  localparam logic [ByteW-1:0] Lead4Min = 8'hf0;
  localparam logic [ByteW-1:0] Lead4Max = 8'hf4;

  localparam logic [SeqW-1:0] Seq1 = 3'd1;
  localparam logic [SeqW-1:0] Seq2 = 3'd2;
  localparam logic [SeqW-1:0] Seq3 = 3'd3;
  localparam logic [SeqW-1:0] Seq4 = 3'd4;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } utf8v_byte_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } utf8v_result_t;

  function automatic logic utf8v_point_ok(input logic [CpW-1:0] cp,
                                          input logic [SeqW-1:0] width,
                                          input logic multiline);
    logic ok;
    ok = 1'b1;
    if ((width == Seq2 && cp < 21'h80) || (width == Seq3 && cp < 21'h800) ||
        (width == Seq4 && cp < 21'h10000)) begin
      ok = 1'b0;
    end else if (cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff)) begin
      ok = 1'b0;
    end else if (cp < 21'h20) begin
      ok = multiline && (cp == 21'h0a || cp == 21'h09);
    end else if (cp == 21'h7f || (cp >= 21'h80 && cp <= 21'h9f) ||
                 (cp >= 21'h200b && cp <= 21'h200f) ||
                 (cp >= 21'h202a && cp <= 21'h202e) ||
                 (cp >= 21'h2066 && cp <= 21'h2069) || cp == 21'hfeff) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

FILE: sv/utf8v_in_stage.sv
module utf8v_in_stage
  import utf8v_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] text_byte,
  input  logic             advance,
  output utf8v_byte_t      stage
);

  logic             held;
  logic [ByteW-1:0] data;

  assign in_stall = held && !advance;
  assign stage    = '{valid: held, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= text_byte;
    end
  end

endmodule

FILE: sv/utf8v_decode.sv
module utf8v_decode
  import utf8v_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  utf8v_byte_t     stage,
  input  logic            advance,
  input  logic [LenW-1:0] max_length,
  input  logic            multiline_en,
  output utf8v_result_t   result
);

  logic              error_seen;
  logic [PendW-1:0]  bytes_pending;
  logic [SeqW-1:0]   sequence_width;
  logic [CpW-1:0]    code_point_acc;
  logic [CountW-1:0] byte_count;

  logic              error_seen_next;
  logic [PendW-1:0]  bytes_pending_next;
  logic [SeqW-1:0]   sequence_width_next;
  logic [CpW-1:0]    code_point_acc_next;
  logic [CountW-1:0] byte_count_next;

  logic             fire;
  logic [ByteW-1:0] b;
  logic [CpW-1:0]   cp_shift;

  assign fire     = stage.valid && advance;
  assign b        = stage.data;
  assign cp_shift = {code_point_acc[CpW-7:0], b[5:0]};

  always_comb begin
    error_seen_next     = error_seen;
    bytes_pending_next  = bytes_pending;
    sequence_width_next = sequence_width;
    code_point_acc_next = code_point_acc;
    byte_count_next     = byte_count;
    result              = '{valid: 1'b0, ok: 1'b0};
    if (fire) begin
      if (b == '0) begin
        result.valid = 1'b1;
        result.ok    = !error_seen && bytes_pending == '0 && byte_count != '0 &&
                       byte_count <= {1'b0, max_length};
        error_seen_next     = 1'b0;
        bytes_pending_next  = '0;
        sequence_width_next = '0;
        code_point_acc_next = '0;
        byte_count_next     = '0;
      end else begin
        if (byte_count != CountMax) begin
          byte_count_next = byte_count + CountW'(1);
        end
        if (error_seen) begin
          bytes_pending_next  = '0;
          sequence_width_next = '0;
          code_point_acc_next = '0;
        end else if (bytes_pending == '0) begin
          if (!b[7]) begin
            if (!utf8v_point_ok(CpW'(b), Seq1, multiline_en)) begin
              error_seen_next = 1'b1;
            end
          end else if (b >= Lead2Min && b <= Lead2Max) begin
            code_point_acc_next = CpW'(b[4:0]);
            sequence_width_next = Seq2;
            bytes_pending_next  = PendW'(1);
          end else if (b >= Lead3Min && b <= Lead3Max) begin
            code_point_acc_next = CpW'(b[3:0]);
            sequence_width_next = Seq3;
            bytes_pending_next  = PendW'(2);
          end else if (b >= Lead4Min && b <= Lead4Max) begin
            code_point_acc_next = CpW'(b[2:0]);
            sequence_width_next = Seq4;
            bytes_pending_next  = PendW'(3);
          end else begin
            error_seen_next = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          error_seen_next     = 1'b1;
          bytes_pending_next  = '0;
          sequence_width_next = '0;
          code_point_acc_next = '0;
        end else begin
          bytes_pending_next = bytes_pending - PendW'(1);
          if (bytes_pending == PendW'(1)) begin
            if (!utf8v_point_ok(cp_shift, sequence_width, multiline_en)) begin
              error_seen_next = 1'b1;
            end
            sequence_width_next = '0;
            code_point_acc_next = '0;
          end else begin
            code_point_acc_next = cp_shift;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen     <= 1'b0;
      bytes_pending  <= '0;
      sequence_width <= '0;
      code_point_acc <= '0;
      byte_count     <= '0;
    end else begin
      error_seen     <= error_seen_next;
      bytes_pending  <= bytes_pending_next;
      sequence_width <= sequence_width_next;
      code_point_acc <= code_point_acc_next;
      byte_count     <= byte_count_next;
    end
  end

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && b == '0) |=> (byte_count == '0 && bytes_pending == '0 && !error_seen))
    else $error("State not cleared after a terminator.");

  a_idle_seq_empty: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending == '0) |-> (code_point_acc == '0 && sequence_width == '0))
    else $error("Partial code point left with nothing pending.");

  a_error_no_pending: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> bytes_pending == '0)
    else $error("Continuation bytes pending after an error.");

  a_pending_fits_width: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != '0) |->
      (sequence_width >= Seq2 && sequence_width <= Seq4 &&
       {1'b0, bytes_pending} < sequence_width))
    else $error("Pending count does not fit the sequence width.");
`endif

endmodule

FILE: sv/utf8v_out_stage.sv
module utf8v_out_stage
  import utf8v_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  utf8v_result_t result,
  output logic          advance,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          text_valid
);

  assign advance = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      text_valid <= result.ok;
    end
  end

endmodule

FILE: sv/utf8_text_validator.sv
// Strict UTF-8 checker for NUL-terminated text, one byte per transaction on
// the input channel. Every byte runs through an input register, combinational
// decode and code point checks, and a result register, so a new byte can be
// taken every cycle unless the output stalls, and a result is offered once the
// zero byte has passed both registers. A stalled output holds both registers,
// and the input stalls in the same cycle once a byte is waiting.
// Only the zero byte produces an output transaction: text_valid is 1 when the
// string is nonempty, no longer than max_length bytes, decodes without error
// and holds no rejected code point (controls, DEL, C1, zero width, bidi marks
// and BOM; newline and tab pass when multiline text is enabled).
// Configuration writes are always taken and should be made while no string is
// in flight.
module utf8_text_validator
  import utf8v_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] text_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             text_valid,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [LenW-1:0]  cfg_data
);

  logic [LenW-1:0] max_length;
  logic            multiline_en;
  logic            advance;
  utf8v_byte_t     stage;
  utf8v_result_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length   <= MaxLengthReset;
      multiline_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgMaxLength:      max_length   <= cfg_data;
        CfgAllowMultiline: multiline_en <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  utf8v_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .advance   (advance),
    .stage     (stage)
  );

  utf8v_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .advance      (advance),
    .max_length   (max_length),
    .multiline_en (multiline_en),
    .result       (result)
  );

  utf8v_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .text_valid (text_valid)
  );

endmodule
